// File: design/vbd_pkg.sv
// vbd_pkg: shared widths, register indexes and types for the volume box downscaler
// used by every module of the design; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vbd_pkg;

	// sizing of the filter
	localparam int MAX_SCALE = 16;
	localparam int MAX_DIM   = 1024;

	// fixed register and field widths
	localparam int PIX_W   = 32;
	localparam int CH_W    = 8;
	localparam int SCALE_W = 5;
	localparam int DIM_W   = 11;
	localparam int OFS_W   = 9;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 11;

	// derived widths
	localparam int INNER_W = $clog2(MAX_SCALE);
	localparam int OUTER_W = $clog2(MAX_DIM);
	localparam int SUM_W   = CH_W + 3 * INNER_W;
	localparam int CNT_W   = 3 * INNER_W + 1;
	localparam int REM_W   = SUM_W + 1;
	localparam int DSR_W   = CNT_W + CH_W - 1;
	localparam int STEP_W  = $clog2(CH_W);
	localparam int NCH     = 4;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register indexes
	localparam logic [IDX_W-1:0] REG_SCALE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEPTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_OFFSET = 3'd4;
	localparam logic [IDX_W-1:0] REG_SKIP   = 3'd5;

	// channel lanes inside a word
	localparam int CH_ALPHA = 3;

	// configuration register file
	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [DIM_W-1:0]   depth;
		logic [OFS_W-1:0]   alpha_offset;
		logic               skip;
	} cfg_t;

	// one finished block handed from front to back
	typedef struct packed {
		logic [NCH-1:0][SUM_W-1:0] sums;
		logic [CNT_W-1:0]          count;
		logic                      last;
	} blk_t;

	// back end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage
`default_nettype wire

// File: design/vbd_fifo.sv
// vbd_fifo: small queue of finished block sums between front and back
// depends on vbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module vbd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire vbd_pkg::blk_t push_data,
	output logic               full,
	input  wire logic          pop,
	output vbd_pkg::blk_t      pop_data,
	output logic               empty
);
	import vbd_pkg::*;

	blk_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/vbd_front.sv
// vbd_front: accumulates texels of each sample block and walks the box and output grid
// depends on vbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module vbd_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire vbd_pkg::cfg_t           cfg,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [vbd_pkg::PIX_W-1:0] texel,
	output logic                         push,
	output vbd_pkg::blk_t                push_data,
	input  wire logic                    queue_full
);
	import vbd_pkg::*;

	logic [NCH-1:0][SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [INNER_W-1:0]        inx_q, iny_q, inz_q;
	logic [OUTER_W-1:0]        outx_q, outy_q, outz_q;

	logic [NCH-1:0][SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0]          cnt_nx;
	logic [DIM_W-1:0]          dw, dh, dd;
	logic [SCALE_W-1:0]        sw, sh, sd;
	logic                      counted, accept;
	logic                      wix, wiy, wiz, block_end;
	logic                      wox, woy, woz;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

	function automatic logic [SCALE_W-1:0] eff_sample(input logic [SCALE_W-1:0] s,
		input logic [DIM_W-1:0] d);
		logic [SCALE_W-1:0] c;
		if (s == '0) begin
			c = SCALE_W'(1);
		end else if (s > SCALE_W'(MAX_SCALE)) begin
			c = SCALE_W'(MAX_SCALE);
		end else begin
			c = s;
		end
		if (DIM_W'(c) < d) begin
			return c;
		end
		return d[SCALE_W-1:0];
	endfunction

	// inner counter wraps once its next value reaches the box size
	function automatic logic inner_wrap(input logic [INNER_W-1:0] c,
		input logic [SCALE_W-1:0] s);
		return ({1'b0, c} + 1'b1) >= s;
	endfunction

	// outer counter wraps when (c + 2) * s exceeds the dimension, i.e. c + 1 >= dim / s
	function automatic logic outer_wrap(input logic [OUTER_W-1:0] c,
		input logic [SCALE_W-1:0] s, input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0]         c2;
		logic [DIM_W+SCALE_W-1:0] prod;
		c2   = DIM_W'(c) + DIM_W'(2);
		prod = (DIM_W+SCALE_W)'(c2) * (DIM_W+SCALE_W)'(s);
		return prod > (DIM_W+SCALE_W)'(d);
	endfunction

	// effective geometry
	always_comb begin
		dw = eff_dim(cfg.width);
		dh = eff_dim(cfg.height);
		dd = eff_dim(cfg.depth);
		sw = eff_sample(cfg.scale, dw);
		sh = eff_sample(cfg.scale, dh);
		sd = eff_sample(cfg.scale, dd);
	end

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// running sums including the current word
	always_comb begin
		counted = (texel[PIX_W-1 -: CH_W] != '0) || !cfg.skip;
		for (int i = 0; i < NCH; i++) begin
			sum_nx[i] = sum_q[i] + (counted ? SUM_W'(texel[i*CH_W +: CH_W]) : '0);
		end
		cnt_nx = cnt_q + (counted ? CNT_W'(1) : '0);
	end

	// box and grid position
	always_comb begin
		wix       = inner_wrap(inx_q, sw);
		wiy       = inner_wrap(iny_q, sh);
		wiz       = inner_wrap(inz_q, sd);
		block_end = wix && wiy && wiz;
		wox       = outer_wrap(outx_q, sw, dw);
		woy       = outer_wrap(outy_q, sh, dh);
		woz       = outer_wrap(outz_q, sd, dd);
	end

	assign push            = accept && block_end;
	assign push_data.sums  = sum_nx;
	assign push_data.count = cnt_nx;
	assign push_data.last  = wox && woy && woz;

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (block_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inx_q  <= '0;
			iny_q  <= '0;
			inz_q  <= '0;
			outx_q <= '0;
			outy_q <= '0;
			outz_q <= '0;
		end else if (accept) begin
			inx_q <= wix ? '0 : inx_q + 1'b1;
			if (wix) begin
				iny_q <= wiy ? '0 : iny_q + 1'b1;
			end
			if (wix && wiy) begin
				inz_q <= wiz ? '0 : inz_q + 1'b1;
			end
			if (block_end) begin
				outx_q <= wox ? '0 : outx_q + 1'b1;
				if (wox) begin
					outy_q <= woy ? '0 : outy_q + 1'b1;
				end
				if (wox && woy) begin
					outz_q <= woz ? '0 : outz_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: design/vbd_back.sv
// vbd_back: rounded averages by four-lane bit-serial division, alpha bias and clamp,
// and the output register; depends on vbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module vbd_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [vbd_pkg::OFS_W-1:0] alpha_offset,
	input  wire logic                      queue_empty,
	input  wire vbd_pkg::blk_t             pop_data,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [vbd_pkg::PIX_W-1:0]      voxel,
	output logic                           volume_done
);
	import vbd_pkg::*;

	bk_state_t                 state_q, state_nx;
	logic [NCH-1:0][REM_W-1:0] rem_q;
	logic [NCH-1:0][CH_W-1:0]  quo_q;
	logic [DSR_W-1:0]          dsr_q;
	logic [STEP_W-1:0]         step_q;
	logic                      zero_q, last_q;
	logic                      out_valid_q;
	logic [PIX_W-1:0]          voxel_q;
	logic                      done_q;

	logic                      out_load;
	logic signed [CH_W+1:0]    av;
	logic [CH_W-1:0]           a_clamp;
	logic [PIX_W-1:0]          result;

	assign pop      = (state_q == BK_IDLE) && !queue_empty;
	assign out_load = (state_q == BK_DONE) && (!out_valid_q || out_ready);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!queue_empty) begin
					state_nx = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(CH_W - 1)) begin
					state_nx = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_load) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// restoring division, one quotient bit per lane each cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < NCH; i++) begin
				rem_q[i] <= {1'b0, pop_data.sums[i]} + REM_W'(pop_data.count >> 1);
				quo_q[i] <= '0;
			end
			dsr_q  <= {pop_data.count, {(CH_W-1){1'b0}}};
			step_q <= '0;
			zero_q <= (pop_data.count == '0);
			last_q <= pop_data.last;
		end else if (state_q == BK_DIV) begin
			for (int i = 0; i < NCH; i++) begin
				if (rem_q[i] >= {1'b0, dsr_q}) begin
					rem_q[i] <= rem_q[i] - {1'b0, dsr_q};
					quo_q[i] <= {quo_q[i][CH_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][CH_W-2:0], 1'b0};
				end
			end
			dsr_q  <= dsr_q >> 1;
			step_q <= step_q + 1'b1;
		end
	end

	// alpha bias and clamp, word assembly
	always_comb begin
		av = $signed({2'b00, quo_q[CH_ALPHA]})
			+ $signed({alpha_offset[OFS_W-1], alpha_offset});
		if (av < 0) begin
			a_clamp = '0;
		end else if (av > $signed((CH_W+2)'(255))) begin
			a_clamp = 8'hFF;
		end else begin
			a_clamp = av[CH_W-1:0];
		end
		if (zero_q) begin
			result = '0;
		end else begin
			result = {a_clamp, quo_q[2], quo_q[1], quo_q[0]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			voxel_q <= result;
			done_q  <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign voxel       = voxel_q;
	assign volume_done = done_q;

endmodule
`default_nettype wire

// File: design/volume_box_downscale_argb.sv
// volume_box_downscale_argb: top level with the register file, front, queue and back
// depends on vbd_pkg, vbd_front, vbd_fifo, vbd_back
//
// Usage:
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six registers;
//   cfg_ready is always high. Write only while no volume is in flight.
// - in channel (in_valid/in_ready, texel) takes one ARGB source word per cycle while
//   in_ready is high, in block order: each voxel's sample block in z, y, x order.
// - out channel (out_valid/out_ready, voxel, volume_done) gives one averaged word per
//   block; volume_done marks the last voxel of the volume.
// Result path: a block's sums are pushed into the queue when its last texel is taken,
// popped into the divider when the back is idle, averaged by four-lane bit-serial
// division, and loaded into the output register.
// Throughput: texels are taken one per cycle while the 4-entry block queue has room;
// the divider works on one block at a time and pops the next only once the last result
// has gone into the output register; the front keeps filling the queue meanwhile.
// When the receiver stalls the result holds in the output register, the divider
// finishes the next block and waits, and the queue fills before in_ready drops.
// Reset clears all sums, counters, the queue and the output valid flag; registers go to
// scale 1, dimensions 1, offset 0, skipping off.
`timescale 1ns / 1ps
`default_nettype none
module volume_box_downscale_argb (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [vbd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [vbd_pkg::DATA_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [vbd_pkg::PIX_W-1:0]   texel,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [vbd_pkg::PIX_W-1:0]        voxel,
	output logic                             volume_done
);
	import vbd_pkg::*;

	cfg_t cfg_q;
	blk_t push_data, pop_data;
	logic push, pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale        <= SCALE_W'(1);
			cfg_q.width        <= DIM_W'(1);
			cfg_q.height       <= DIM_W'(1);
			cfg_q.depth        <= DIM_W'(1);
			cfg_q.alpha_offset <= '0;
			cfg_q.skip         <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCALE:  cfg_q.scale        <= cfg_data[SCALE_W-1:0];
				REG_WIDTH:  cfg_q.width        <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height       <= cfg_data[DIM_W-1:0];
				REG_DEPTH:  cfg_q.depth        <= cfg_data[DIM_W-1:0];
				REG_OFFSET: cfg_q.alpha_offset <= cfg_data[OFS_W-1:0];
				REG_SKIP:   cfg_q.skip         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// accumulation front
	vbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.texel      (texel),
		.push       (push),
		.push_data  (push_data),
		.queue_full (q_full)
	);

	// block queue
	vbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// averaging back
	vbd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.alpha_offset (cfg_q.alpha_offset),
		.queue_empty  (q_empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.voxel        (voxel),
		.volume_done  (volume_done)
	);

endmodule
`default_nettype wire

// File: verif/testbench.sv
// testbench: self-checking bench for volume_box_downscale_argb, the 3D ARGB box-filter downscaler
// depends on vbd_pkg and the design sources; predicts every averaged voxel and its volume flag
`timescale 1ns / 1ps
module testbench;
	import vbd_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam longint TIMEOUT_NS = 64'd10_000_000;
	localparam int RANDOM_PHASES = 17;
	localparam int HOLD_PHASE = 1;
	localparam int WIDE_PHASE = 3;
	// index that selects no register
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	// one expected output word
	typedef struct packed {
		logic [PIX_W-1:0] voxel;
		logic             done;
	} out_word_t;

	// running box average, mirrors the block's sums and counters
	class box_average_tracker;
		logic [SCALE_W-1:0] scale;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [DIM_W-1:0]   depth;
		logic [OFS_W-1:0]   alpha_ofs;
		logic               skip;
		int unsigned        sum_a, sum_r, sum_g, sum_b, n_counted;
		int unsigned        ix, iy, iz, ox, oy, oz;
		out_word_t          pending_voxels[$];
		int                 errors;

		function new();
			scale = 1;
			width = 1;
			height = 1;
			depth = 1;
			alpha_ofs = '0;
			skip = 1'b0;
			sum_a = 0;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			n_counted = 0;
			ix = 0;
			iy = 0;
			iz = 0;
			ox = 0;
			oy = 0;
			oz = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_SCALE:  scale = data[SCALE_W-1:0];
				REG_WIDTH:  width = data[DIM_W-1:0];
				REG_HEIGHT: height = data[DIM_W-1:0];
				REG_DEPTH:  depth = data[DIM_W-1:0];
				REG_OFFSET: alpha_ofs = data[OFS_W-1:0];
				REG_SKIP:   skip = data[0];
				default: ;
			endcase
		endfunction

		// zero acts as one, large sizes saturate
		function int unsigned clamp_dim(logic [DIM_W-1:0] d);
			if (d == 0)
				return 1;
			if (d > MAX_DIM)
				return MAX_DIM;
			return d;
		endfunction

		function int unsigned box_size(int unsigned dim);
			int unsigned s;
			s = scale;
			if (s == 0)
				s = 1;
			if (s > MAX_SCALE)
				s = MAX_SCALE;
			return (s < dim) ? s : dim;
		endfunction

		// step a counter, report a wrap; counters past a new limit wrap at once
		function bit step_wraps(inout int unsigned c, input int unsigned lim);
			if (c + 1 >= lim) begin
				c = 0;
				return 1'b1;
			end
			c = c + 1;
			return 1'b0;
		endfunction

		function int unsigned rounded_mean(int unsigned s, int unsigned n);
			return (s + n / 2) / n;
		endfunction

		function int pending_count();
			return pending_voxels.size();
		endfunction

		// accumulate one accepted texel, queue a voxel when its box closes
		function void take_texel(logic [PIX_W-1:0] t);
			int unsigned dw, dh, dd, sw, sh, sd;
			int          alpha;
			logic [31:0] ch_r, ch_g, ch_b;
			out_word_t   w;
			dw = clamp_dim(width);
			dh = clamp_dim(height);
			dd = clamp_dim(depth);
			sw = box_size(dw);
			sh = box_size(dh);
			sd = box_size(dd);
			if (t[3*CH_W +: CH_W] != 0 || !skip) begin
				sum_a += t[3*CH_W +: CH_W];
				sum_r += t[2*CH_W +: CH_W];
				sum_g += t[CH_W +: CH_W];
				sum_b += t[0 +: CH_W];
				n_counted++;
			end
			if (!step_wraps(ix, sw))
				return;
			if (!step_wraps(iy, sh))
				return;
			if (!step_wraps(iz, sd))
				return;
			// box closed: average, bias and clamp alpha
			w = '0;
			if (n_counted != 0) begin
				alpha = int'(rounded_mean(sum_a, n_counted)) + int'($signed(alpha_ofs));
				if (alpha < 0)
					alpha = 0;
				if (alpha > 255)
					alpha = 255;
				ch_r = rounded_mean(sum_r, n_counted);
				ch_g = rounded_mean(sum_g, n_counted);
				ch_b = rounded_mean(sum_b, n_counted);
				w.voxel = {alpha[CH_W-1:0], ch_r[CH_W-1:0], ch_g[CH_W-1:0], ch_b[CH_W-1:0]};
			end
			sum_a = 0;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			n_counted = 0;
			// output grid position, volume ends when all three wrap
			if (step_wraps(ox, dw / sw))
				if (step_wraps(oy, dh / sh))
					if (step_wraps(oz, dd / sd))
						w.done = 1'b1;
			pending_voxels.push_back(w);
		endfunction

		function void check_voxel(logic [PIX_W-1:0] v, logic d);
			out_word_t w;
			if (pending_voxels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected voxel %08h done %0b at %0t", v, d, $realtime);
				return;
			end
			w = pending_voxels.pop_front();
			if (v !== w.voxel || d !== w.done) begin
				errors++;
				if (errors <= 10)
					$display("voxel mismatch at %0t: expected %08h done %0b, got %08h done %0b",
						$realtime, w.voxel, w.done, v, d);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [DATA_W-1:0]   cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [PIX_W-1:0]    texel;
	logic                out_valid;
	logic                out_ready;
	logic [PIX_W-1:0]    voxel;
	logic                volume_done;

	box_average_tracker sb = new();
	bit long_hold = 1'b0;
	int tx_calm = 0;
	int rx_calm = 0;

	volume_box_downscale_argb DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.texel(texel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.voxel(voxel),
		.volume_done(volume_done)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// idle cycles before a word, with occasional stretches of none
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic logic [PIX_W-1:0] random_texel();
		logic [PIX_W-1:0] t;
		t = $urandom;
		case ($urandom_range(0, 7))
			0, 1: t[3*CH_W +: CH_W] = '0;
			2: t[3*CH_W +: CH_W] = '1;
			3: t = '0;
			default: ;
		endcase
		return t;
	endfunction

	function automatic logic [DATA_W-1:0] random_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DATA_W'($urandom_range(6, 16));
			default: return DATA_W'($urandom_range(1, 5));
		endcase
	endfunction

	// config write; caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic send_texel(input logic [PIX_W-1:0] value);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		texel <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_texel(value);
	endtask

	// drop valid, drain every expected voxel, let partial boxes settle
	task automatic end_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_random_regs();
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_SCALE, ($urandom_range(0, 5) == 0) ?
				DATA_W'($urandom_range(0, 31)) : DATA_W'($urandom_range(1, 4)));
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_WIDTH, random_dim());
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_HEIGHT, random_dim());
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_DEPTH, random_dim());
		if ($urandom_range(0, 1) != 0)
			write_reg(REG_OFFSET, DATA_W'($urandom));
		if ($urandom_range(0, 1) != 0)
			write_reg(REG_SKIP, DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls plus one long hold on request
	initial begin
		int n;
		forever begin
			n = draw_wait(rx_calm);
			if (long_hold) begin
				n = LONG_HOLD_CYCLES;
				long_hold = 1'b0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_voxel(voxel, volume_done);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int n_items;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		texel <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every texel is a full volume
		send_texel(32'hFFFF_FFFF);
		send_texel(32'h0000_0000);
		send_texel(32'h8040_2010);
		end_phase();

		// scale zero acts as one, alpha clamps high, skipped texel leaves an empty box
		write_reg(REG_SCALE, 11'd0);
		write_reg(REG_WIDTH, 11'd2);
		write_reg(REG_OFFSET, 11'd255);
		write_reg(REG_SKIP, 11'd1);
		cfg_valid <= 1'b0;
		send_texel(32'h01AB_CDEF);
		send_texel(32'h00FF_FFFF);
		end_phase();

		// most negative bias clamps alpha low, rounding of half up
		write_reg(REG_OFFSET, 11'h100);
		write_reg(REG_SKIP, 11'd0);
		write_reg(REG_SCALE, 11'd2);
		cfg_valid <= 1'b0;
		send_texel(32'hFF01_0101);
		send_texel(32'h0100_0000);
		end_phase();

		// oversized scale saturates, zero dimensions act as one, skipping inside a box
		write_reg(REG_SCALE, 11'd31);
		write_reg(REG_WIDTH, 11'd3);
		write_reg(REG_HEIGHT, 11'd0);
		write_reg(REG_DEPTH, 11'd0);
		write_reg(REG_OFFSET, 11'h101);
		write_reg(REG_SKIP, 11'd1);
		cfg_valid <= 1'b0;
		send_texel(32'h0012_3456);
		send_texel(32'h05FF_FFFF);
		send_texel(32'h0000_0000);
		end_phase();

		// grid shrinks mid volume: counter past the new limit wraps on its next step
		write_reg(REG_SCALE, 11'd1);
		write_reg(REG_WIDTH, 11'd3);
		write_reg(REG_HEIGHT, 11'd2);
		write_reg(REG_DEPTH, 11'd1);
		write_reg(REG_OFFSET, 11'd0);
		write_reg(REG_SKIP, 11'd0);
		write_reg(REG_NONE, 11'h7FF);
		cfg_valid <= 1'b0;
		send_texel(random_texel());
		send_texel(random_texel());
		end_phase();
		write_reg(REG_WIDTH, 11'd2);
		cfg_valid <= 1'b0;
		repeat (4) send_texel(random_texel());
		end_phase();

		// random phases, each with its own settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == HOLD_PHASE) begin
				// one-texel boxes and a stalled receiver fill the block queue up
				write_reg(REG_SCALE, 11'd1);
				write_reg(REG_WIDTH, random_dim());
				write_reg(REG_HEIGHT, random_dim());
				cfg_valid <= 1'b0;
				long_hold = 1'b1;
				tx_calm = 100;
				n_items = 80;
			end else if (p == WIDE_PHASE) begin
				// widest volume, dimension saturates to the maximum
				write_reg(REG_SCALE, ($urandom_range(0, 1) != 0) ? 11'd16 : 11'd31);
				write_reg(REG_WIDTH, ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'h7FF);
				write_reg(REG_HEIGHT, 11'd1);
				write_reg(REG_DEPTH, 11'd1);
				write_reg(REG_SKIP, DATA_W'($urandom));
				cfg_valid <= 1'b0;
				n_items = 1040;
			end else begin
				program_random_regs();
				n_items = $urandom_range(10, 60);
			end
			repeat (n_items) send_texel(random_texel());
			end_phase();
		end

		if (sb.errors == 0 && sb.pending_count() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: volume_box_downscale_argb.f
design/vbd_pkg.sv
design/vbd_fifo.sv
design/vbd_front.sv
design/vbd_back.sv
design/volume_box_downscale_argb.sv
verif/testbench.sv
